// ----- hdl/cpbb_pkg.sv -----
// cpbb_pkg: constants, register map and shared types of the covered pixel
// bounding box unit. Depends on nothing; every other file imports it.
`timescale 1ns / 1ps

package cpbb_pkg;

   // Frame geometry and field widths
   localparam int MAX_DIM   = 4096;
   localparam int COORD_W   = 12;
   localparam int WIDTH_W   = 13;
   localparam int COUNT_W   = 25;
   localparam int PIXEL_W   = 32;
   localparam int ALPHA_SHIFT = 24;

   localparam logic [COUNT_W-1:0] COUNT_LIMIT        = COUNT_W'(1 << 24);
   localparam logic [PIXEL_W-1:0] COLOUR_NIBBLE_MASK = 32'h00F0F0F0;
   localparam logic [WIDTH_W-1:0] LINE_WIDTH_RESET   = WIDTH_W'(MAX_DIM);
   localparam logic [WIDTH_W-1:0] WIDTH_MAX          = WIDTH_W'(MAX_DIM);
   localparam logic [COORD_W-1:0] ROW_LAST           = COORD_W'(MAX_DIM - 1);

   // Register interface: two 32-bit registers at byte offsets 0 and 4
   localparam int ADDR_W = 3;
   localparam int DATA_W = 32;
   localparam logic REG_BY_ALPHA   = 1'b0;
   localparam logic REG_LINE_WIDTH = 1'b1;

   // Configuration seen by the accumulator
   typedef struct packed {
      logic               by_alpha;
      logic [WIDTH_W-1:0] line_width;
   } cfg_type;

   // One finished frame summary
   typedef struct packed {
      logic               any_covered;
      logic [COORD_W-1:0] min_x;
      logic [COORD_W-1:0] max_x;
      logic [COORD_W-1:0] min_y;
      logic [COORD_W-1:0] max_y;
      logic [COUNT_W-1:0] covered_count;
   } box_type;

endpackage

// ----- hdl/cpbb_csr.sv -----
// cpbb_csr: register file for the coverage mode and the line width.
// Depends on cpbb_pkg.
`timescale 1ns / 1ps

module cpbb_csr
   import cpbb_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output cfg_type           cfg
);

   logic               by_alpha_ff;
   logic [WIDTH_W-1:0] line_width_ff;
   logic               wr_en;

   // write strobe in the access phase; pready is tied high
   assign wr_en = psel && penable && pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         by_alpha_ff   <= 1'b0;
         line_width_ff <= LINE_WIDTH_RESET;
      end else if (wr_en) begin
         unique case (paddr[2])
            REG_BY_ALPHA:   by_alpha_ff   <= pwdata[0];
            REG_LINE_WIDTH: line_width_ff <= pwdata[WIDTH_W-1:0];
            default: ;
         endcase
      end
   end

   // read mux
   always_comb begin
      unique case (paddr[2])
         REG_BY_ALPHA:   prdata = {{(DATA_W-1){1'b0}}, by_alpha_ff};
         REG_LINE_WIDTH: prdata = {{(DATA_W-WIDTH_W){1'b0}}, line_width_ff};
         default:        prdata = '0;
      endcase
   end

   assign cfg.by_alpha   = by_alpha_ff;
   assign cfg.line_width = line_width_ff;

endmodule

// ----- hdl/cpbb_accum.sv -----
// cpbb_accum: raster position counters and per-frame box/count accumulator.
// Depends on cpbb_pkg.
`timescale 1ns / 1ps

module cpbb_accum
   import cpbb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               fire,
   input  logic [PIXEL_W-1:0] pixel,
   input  logic               frame_end,
   output box_type            result
);

   logic [COORD_W-1:0] col_ff,   col_in;
   logic [COORD_W-1:0] row_ff,   row_in;
   logic [COORD_W-1:0] min_x_ff, min_x_in;
   logic [COORD_W-1:0] max_x_ff, max_x_in;
   logic [COORD_W-1:0] min_y_ff, min_y_in;
   logic [COORD_W-1:0] max_y_ff, max_y_in;
   logic [COUNT_W-1:0] count_ff, count_in;

   logic [WIDTH_W-1:0] eff_width;
   logic [WIDTH_W-1:0] col_next;
   logic               covered;

   // clamp the programmed width into 1..MAX_DIM
   always_comb begin
      priority if (cfg.line_width == '0)
         eff_width = WIDTH_W'(1);
      else if (cfg.line_width > WIDTH_MAX)
         eff_width = WIDTH_MAX;
      else
         eff_width = cfg.line_width;
   end

   // coverage test
   always_comb begin
      if (cfg.by_alpha)
         covered = |pixel[PIXEL_W-1:ALPHA_SHIFT];
      else
         covered = |(pixel & COLOUR_NIBBLE_MASK);
   end

   assign col_next = {1'b0, col_ff} + WIDTH_W'(1);

   // box and count update, including the current word
   always_comb begin
      min_x_in = min_x_ff;
      max_x_in = max_x_ff;
      min_y_in = min_y_ff;
      max_y_in = max_y_ff;
      count_in = count_ff;
      if (covered) begin
         if (count_ff == '0) begin
            min_x_in = col_ff;
            max_x_in = col_ff;
            min_y_in = row_ff;
            max_y_in = row_ff;
         end else begin
            if (col_ff < min_x_ff) min_x_in = col_ff;
            if (col_ff > max_x_ff) max_x_in = col_ff;
            max_y_in = row_ff;
         end
         if (count_ff < COUNT_LIMIT) count_in = count_ff + COUNT_W'(1);
      end
   end

   // raster position; row saturates on the last row
   always_comb begin
      if (col_next >= eff_width) begin
         col_in = '0;
         row_in = (row_ff < ROW_LAST) ? row_ff + COORD_W'(1) : row_ff;
      end else begin
         col_in = col_next[COORD_W-1:0];
         row_in = row_ff;
      end
   end

   // frame summary as it stands after this word
   assign result.any_covered   = (count_in != '0);
   assign result.min_x         = min_x_in;
   assign result.max_x         = max_x_in;
   assign result.min_y         = min_y_in;
   assign result.max_y         = max_y_in;
   assign result.covered_count = count_in;

   // state registers; the frame-end word clears everything
   always_ff @(posedge clock) begin
      if (reset || (fire && frame_end)) begin
         col_ff   <= '0;
         row_ff   <= '0;
         min_x_ff <= '0;
         max_x_ff <= '0;
         min_y_ff <= '0;
         max_y_ff <= '0;
         count_ff <= '0;
      end else if (fire) begin
         col_ff   <= col_in;
         row_ff   <= row_in;
         min_x_ff <= min_x_in;
         max_x_ff <= max_x_in;
         min_y_ff <= min_y_in;
         max_y_ff <= max_y_in;
         count_ff <= count_in;
      end
   end

   // an empty frame keeps a zero box
   a_empty_box_zero: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0) |-> (min_x_ff == '0 && max_x_ff == '0 &&
                            min_y_ff == '0 && max_y_ff == '0))
      else $error("box not zero while no pixel counted");

   // the box is never inverted
   a_box_ordered: assert property (@(posedge clock) disable iff (reset)
      (min_x_ff <= max_x_ff) && (min_y_ff <= max_y_ff))
      else $error("bounding box inverted");

endmodule

// ----- hdl/covered_pixel_bounding_box_unit.sv -----
// covered_pixel_bounding_box_unit: top level with the input word register,
// the result register and the handshakes. Depends on cpbb_pkg, cpbb_csr,
// cpbb_accum.
`timescale 1ns / 1ps

//  channel  direction  handshake            payload
//  req      in         req_valid/req_stall  req_pixel, req_frame_end
//  rsp      out        rsp_valid/rsp_stall  rsp_any_covered, rsp_min_x .. rsp_covered_count
//  csr      in/out     APB psel/penable     csr_paddr, csr_pwdata, csr_prdata
//
// One pixel per clock while req_stall is low. A frame-end word passes the
// input register, then the result register, before its summary shows up on rsp.
// Reset is synchronous; it restores the register defaults and starts a new
// frame at column 0, row 0.
// req_stall rises only when a frame-end word sits in the input register
// while the previous result is still held by rsp_stall.

module covered_pixel_bounding_box_unit
   import cpbb_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   // pixel words
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [PIXEL_W-1:0] req_pixel,
   input  logic               req_frame_end,
   // frame summaries
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic               rsp_any_covered,
   output logic [COORD_W-1:0] rsp_min_x,
   output logic [COORD_W-1:0] rsp_max_x,
   output logic [COORD_W-1:0] rsp_min_y,
   output logic [COORD_W-1:0] rsp_max_y,
   output logic [COUNT_W-1:0] rsp_covered_count,
   // register port
   input  logic               csr_psel,
   input  logic               csr_penable,
   input  logic               csr_pwrite,
   input  logic [ADDR_W-1:0]  csr_paddr,
   input  logic [DATA_W-1:0]  csr_pwdata,
   output logic [DATA_W-1:0]  csr_prdata,
   output logic               csr_pready
);

   cfg_type            cfg;
   box_type            acc_result;
   box_type            rsp_ff;

   logic               s1_valid_ff;
   logic [PIXEL_W-1:0] s1_pixel_ff;
   logic               s1_end_ff;
   logic               rsp_valid_ff;

   logic               out_free;
   logic               s1_go;
   logic               req_take;

   assign csr_pready = 1'b1;

   cpbb_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .cfg     (cfg)
   );

   // flow control: only a frame-end word needs the result slot
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_go     = s1_valid_ff && (!s1_end_ff || out_free);
   assign req_stall = s1_valid_ff && !s1_go;
   assign req_take  = req_valid && !req_stall;

   // input word register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_take || s1_go) begin
         s1_valid_ff <= req_take;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_pixel_ff <= req_pixel;
         s1_end_ff   <= req_frame_end;
      end
   end

   cpbb_accum u_accum (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .fire      (s1_go),
      .pixel     (s1_pixel_ff),
      .frame_end (s1_end_ff),
      .result    (acc_result)
   );

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_go && s1_end_ff) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_end_ff) begin
         rsp_ff <= acc_result;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_any_covered   = rsp_ff.any_covered;
   assign rsp_min_x         = rsp_ff.min_x;
   assign rsp_max_x         = rsp_ff.max_x;
   assign rsp_min_y         = rsp_ff.min_y;
   assign rsp_max_y         = rsp_ff.max_y;
   assign rsp_covered_count = rsp_ff.covered_count;

   // a retired frame-end word always produces a result next cycle
   a_end_makes_result: assert property (@(posedge clock) disable iff (reset)
      (s1_go && s1_end_ff) |=> rsp_valid_ff)
      else $error("frame-end word retired without a result");

   // back-pressure only from a frame end blocked behind a held result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && s1_end_ff && rsp_valid_ff && rsp_stall))
      else $error("input stalled without a blocked frame end");

endmodule
